>>> rtl/core/kfrt_pkg.sv
// Package for the key-frame request tracker: types, constants and codes.
// No dependencies; used by every module of the block.
`default_nettype none
package kfrt_pkg;
  localparam int unsigned Slots = 16;
  localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned MaxResults = 16;
  localparam logic [15:0] RetryWaitReset = 16'd1000;

  typedef enum logic [1:0] {
    KIND_NEEDED   = 2'd0,
    KIND_FORCED   = 2'd1,
    KIND_RECEIVED = 2'd2,
    KIND_TICK     = 2'd3
  } kind_t;

  localparam logic REG_REQUEST_DELAY = 1'b0;
  localparam logic REG_RETRY_WAIT    = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] stream_id;
  } in_item_t;

  typedef struct packed {
    logic        request_valid;
    logic [31:0] request_stream;
    logic        table_full;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVENT,
    ST_PEND,
    ST_DELAY,
    ST_DONE
  } exec_state_t;
endpackage
`default_nettype wire

>>> rtl/core/kfrt_front.sv
// Input front end: accepts items into a two-entry queue for the back end.
// Depends on kfrt_pkg.
`default_nettype none
module kfrt_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire kfrt_pkg::in_item_t in_item,
  output logic                    q_valid,
  input  wire logic               q_pop,
  output kfrt_pkg::in_item_t      q_item
);
  kfrt_pkg::in_item_t mem [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/kfrt_back.sv
// Execution back end: slot table, event handling and the tick timer sweep.
// Depends on kfrt_pkg.
`default_nettype none
module kfrt_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [15:0]         request_delay,
  input  wire logic [15:0]         retry_wait,
  input  wire logic                q_valid,
  output logic                     q_pop,
  input  wire kfrt_pkg::in_item_t  q_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output kfrt_pkg::out_item_t      out_item
);
  localparam int unsigned N = kfrt_pkg::Slots;
  localparam int unsigned W = kfrt_pkg::SlotW;
  localparam logic [W-1:0] LastSlot = W'(N - 1);

  logic [31:0] slot_stream [N];
  logic [N-1:0] pending_valid, pending_retry, delay_valid, delay_requested;
  logic [15:0] pending_timer [N];
  logic [15:0] delay_timer [N];

  kfrt_pkg::exec_state_t state, state_next;
  kfrt_pkg::in_item_t cur;
  logic [W-1:0] idx;
  logic [4:0] res_count;

  // Held result: emitted on the next result or at the end of the item.
  logic        hold_valid;
  logic [31:0] hold_stream;
  logic        hold_full;

  // Output register.
  logic out_full;
  kfrt_pkg::out_item_t out_reg;
  assign out_valid = out_full;
  assign out_item  = out_reg;

  // Slot search over the table for the current stream.
  logic [N-1:0] used;
  logic         hit_found, free_found;
  logic [W-1:0] hit_idx, free_idx;
  logic [31:0]  lookup_id;

  assign used = pending_valid | delay_valid;

  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (used[i] && slot_stream[i] == lookup_id) begin
        hit_found = 1'b1;
        hit_idx   = W'(i);
      end
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = W'(i);
      end
    end
  end

  // Stream being looked up: the item's stream or the expiring delayer's.
  assign lookup_id = (state == kfrt_pkg::ST_DELAY) ? slot_stream[idx] : cur.stream_id;

  // A new result may be produced only when the output register can take the held one.
  logic can_emit;
  assign can_emit = !hold_valid || !out_full || out_ready;

  // Delayer expiry that needs a re-issued request.
  logic delay_fire;
  assign delay_fire = delay_valid[idx] && (delay_timer[idx] <= 16'd1) &&
                      delay_requested[idx];

  logic step_ok;
  always_comb begin
    step_ok = 1'b1;
    case (state)
      kfrt_pkg::ST_EVENT: step_ok = can_emit;
      kfrt_pkg::ST_PEND:  step_ok = can_emit;
      kfrt_pkg::ST_DELAY: step_ok = can_emit;
      kfrt_pkg::ST_DONE:  step_ok = !hold_valid || !out_full || out_ready;
      default:            step_ok = 1'b1;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      kfrt_pkg::ST_IDLE:
        if (q_valid) begin
          state_next = (kfrt_pkg::kind_t'(q_item.kind) == kfrt_pkg::KIND_TICK) ?
                       kfrt_pkg::ST_PEND : kfrt_pkg::ST_EVENT;
        end
      kfrt_pkg::ST_EVENT:
        if (step_ok) state_next = kfrt_pkg::ST_DONE;
      kfrt_pkg::ST_PEND:
        if (step_ok && idx == LastSlot) state_next = kfrt_pkg::ST_DELAY;
      kfrt_pkg::ST_DELAY:
        if (step_ok && idx == LastSlot) state_next = kfrt_pkg::ST_DONE;
      kfrt_pkg::ST_DONE:
        if (step_ok) state_next = kfrt_pkg::ST_IDLE;
      default: state_next = kfrt_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop = (state == kfrt_pkg::ST_IDLE) && q_valid;
  end

  // Needed-event handling, shared by item events and delayer expiry.
  // Computes table updates for a given slot state.
  logic        nd_emit, nd_full, nd_take, nd_start_delay, nd_mark_req;
  logic        nd_mark_retry, nd_start_pend;
  logic [W-1:0] nd_slot;
  logic        nd_hit;
  logic [W-1:0] nd_hit_idx;

  // During delayer expiry the expiring slot stays in use only while it still
  // holds a pending request; otherwise it is freed first and cannot match.
  always_comb begin
    nd_hit     = hit_found;
    nd_hit_idx = hit_idx;
    if (state == kfrt_pkg::ST_DELAY && hit_found && hit_idx == idx &&
        !pending_valid[idx]) begin
      nd_hit = 1'b0;
      for (int i = N - 1; i >= 0; i--) begin
        if (used[i] && W'(i) != idx && slot_stream[i] == lookup_id) begin
          nd_hit     = 1'b1;
          nd_hit_idx = W'(i);
        end
      end
    end
  end

  // Lowest free slot, counting the expiring delayer slot as free if it becomes so.
  logic free_ok;
  logic [W-1:0] free_sel;
  always_comb begin
    free_ok  = free_found;
    free_sel = free_idx;
    if (state == kfrt_pkg::ST_DELAY && !pending_valid[idx] &&
        (!free_found || idx < free_idx)) begin
      free_ok  = 1'b1;
      free_sel = idx;
    end
  end

  // The expiring delayer no longer counts as a live delayer for its own slot.
  always_comb begin
    nd_emit        = 1'b0;
    nd_full        = 1'b0;
    nd_take        = 1'b0;
    nd_start_delay = 1'b0;
    nd_mark_req    = 1'b0;
    nd_mark_retry  = 1'b0;
    nd_start_pend  = 1'b0;
    nd_slot        = nd_hit ? nd_hit_idx : free_sel;
    if (!nd_hit && !free_ok) begin
      nd_emit = 1'b1;
      nd_full = 1'b1;
    end else if (request_delay != 16'd0 && nd_hit && delay_valid[nd_hit_idx] &&
                 !(state == kfrt_pkg::ST_DELAY && nd_hit_idx == idx)) begin
      nd_mark_req = 1'b1;
    end else begin
      nd_take        = !nd_hit;
      nd_start_delay = (request_delay != 16'd0);
      if (nd_hit && pending_valid[nd_hit_idx]) begin
        nd_mark_retry = 1'b1;
      end else begin
        nd_start_pend = 1'b1;
        nd_emit       = 1'b1;
      end
    end
  end

  // Per-step result request.
  logic        new_emit;
  logic [31:0] new_stream;
  logic        new_full;
  always_comb begin
    new_emit   = 1'b0;
    new_stream = cur.stream_id;
    new_full   = 1'b0;
    case (state)
      kfrt_pkg::ST_EVENT: begin
        case (kfrt_pkg::kind_t'(cur.kind))
          kfrt_pkg::KIND_NEEDED: begin
            new_emit = nd_emit;
            new_full = nd_full;
          end
          kfrt_pkg::KIND_FORCED: begin
            new_emit = 1'b1;
            new_full = !hit_found && !free_found;
          end
          default: new_emit = 1'b0;
        endcase
      end
      kfrt_pkg::ST_PEND: begin
        new_emit   = pending_valid[idx] && pending_timer[idx] <= 16'd1 &&
                     pending_retry[idx];
        new_stream = slot_stream[idx];
      end
      kfrt_pkg::ST_DELAY: begin
        new_emit   = delay_fire && nd_emit;
        new_stream = slot_stream[idx];
        new_full   = nd_full;
      end
      default: new_emit = 1'b0;
    endcase
  end

  logic emit_ok;
  assign emit_ok = new_emit && step_ok && (res_count < 5'(kfrt_pkg::MaxResults));

  // Sequencer registers and result holding.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kfrt_pkg::ST_IDLE;
      hold_valid <= 1'b0;
      out_full   <= 1'b0;
      idx        <= '0;
      res_count  <= '0;
    end else begin
      state <= state_next;
      if (out_full && out_ready) out_full <= 1'b0;
      if (q_pop) begin
        cur       <= q_item;
        idx       <= '0;
        res_count <= '0;
      end
      if ((state == kfrt_pkg::ST_PEND || state == kfrt_pkg::ST_DELAY) && step_ok) begin
        idx <= (idx == LastSlot) ? '0 : idx + W'(1);
      end
      if (emit_ok) begin
        if (hold_valid) begin
          out_full <= 1'b1;
          out_reg  <= '{request_valid: 1'b1, request_stream: hold_stream,
                        table_full: hold_full, last: 1'b0};
        end
        hold_valid  <= 1'b1;
        hold_stream <= new_stream;
        hold_full   <= new_full;
        res_count   <= res_count + 5'd1;
      end
      if (state == kfrt_pkg::ST_DONE && step_ok && hold_valid) begin
        out_full   <= 1'b1;
        out_reg    <= '{request_valid: 1'b1, request_stream: hold_stream,
                        table_full: hold_full, last: 1'b1};
        hold_valid <= 1'b0;
      end
    end
  end

  // Slot table updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid   <= '0;
      pending_retry   <= '0;
      delay_valid     <= '0;
      delay_requested <= '0;
      for (int i = 0; i < N; i++) begin
        pending_timer[i] <= '0;
        delay_timer[i]   <= '0;
      end
    end else if (step_ok) begin
      case (state)
        kfrt_pkg::ST_EVENT: begin
          case (kfrt_pkg::kind_t'(cur.kind))
            kfrt_pkg::KIND_NEEDED: begin
              if (nd_take) slot_stream[nd_slot] <= cur.stream_id;
              if (nd_mark_req) delay_requested[nd_slot] <= 1'b1;
              if (nd_start_delay) begin
                delay_valid[nd_slot]     <= 1'b1;
                delay_requested[nd_slot] <= 1'b0;
                delay_timer[nd_slot]     <= request_delay;
              end
              if (nd_mark_retry) pending_retry[nd_slot] <= 1'b1;
              if (nd_start_pend) begin
                pending_valid[nd_slot] <= 1'b1;
                pending_retry[nd_slot] <= 1'b0;
                pending_timer[nd_slot] <= retry_wait;
              end
            end
            kfrt_pkg::KIND_FORCED: begin
              if (hit_found || free_found) begin
                if (!hit_found) slot_stream[free_idx] <= cur.stream_id;
                if (request_delay != 16'd0) begin
                  delay_valid[nd_slot]     <= 1'b1;
                  delay_requested[nd_slot] <= 1'b0;
                  delay_timer[nd_slot]     <= request_delay;
                end
                pending_valid[nd_slot] <= 1'b1;
                pending_retry[nd_slot] <= hit_found && pending_valid[hit_idx];
                pending_timer[nd_slot] <= retry_wait;
              end
            end
            kfrt_pkg::KIND_RECEIVED: begin
              if (hit_found && pending_valid[hit_idx]) begin
                pending_valid[hit_idx] <= 1'b0;
                pending_retry[hit_idx] <= 1'b0;
                pending_timer[hit_idx] <= '0;
              end
            end
            default: ;
          endcase
        end
        kfrt_pkg::ST_PEND: begin
          if (pending_valid[idx]) begin
            if (pending_timer[idx] > 16'd1) begin
              pending_timer[idx] <= pending_timer[idx] - 16'd1;
            end else if (pending_retry[idx]) begin
              pending_retry[idx] <= 1'b0;
              pending_timer[idx] <= retry_wait;
            end else begin
              pending_valid[idx] <= 1'b0;
              pending_timer[idx] <= '0;
            end
          end
        end
        kfrt_pkg::ST_DELAY: begin
          if (delay_valid[idx]) begin
            if (delay_timer[idx] > 16'd1) begin
              delay_timer[idx] <= delay_timer[idx] - 16'd1;
            end else begin
              delay_valid[idx]     <= 1'b0;
              delay_requested[idx] <= 1'b0;
              delay_timer[idx]     <= '0;
              if (delay_requested[idx]) begin
                // Re-issue the needed event for this stream.
                if (nd_take) slot_stream[nd_slot] <= slot_stream[idx];
                if (nd_mark_req) delay_requested[nd_slot] <= 1'b1;
                if (nd_start_delay) begin
                  delay_valid[nd_slot]     <= 1'b1;
                  delay_requested[nd_slot] <= 1'b0;
                  delay_timer[nd_slot]     <= request_delay;
                end
                if (nd_mark_retry) pending_retry[nd_slot] <= 1'b1;
                if (nd_start_pend) begin
                  pending_valid[nd_slot] <= 1'b1;
                  pending_retry[nd_slot] <= 1'b0;
                  pending_timer[nd_slot] <= retry_wait;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/key_frame_request_tracker.sv
// Key-frame request tracker top level: config registers, front queue, back end.
// A request or received event passes through the idle, event and done states; a
// tick sweeps all slots for pending timers, then for delayer timers, one slot a
// cycle unless the output stalls. The back end takes an item only when idle.
// Synchronous active-high reset clears all control state and the slot valid
// flags and timers; retry_wait resets to 1000 and request_delay to 0.
`default_nettype none
module key_frame_request_tracker (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire kfrt_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output kfrt_pkg::out_item_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [15:0]          cfg_data
);
  logic [15:0] request_delay;
  logic [15:0] retry_wait;
  logic q_valid, q_pop;
  kfrt_pkg::in_item_t q_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      request_delay <= '0;
      retry_wait    <= kfrt_pkg::RetryWaitReset;
    end else if (cfg_we) begin
      if (cfg_index == kfrt_pkg::REG_REQUEST_DELAY) request_delay <= cfg_data;
      if (cfg_index == kfrt_pkg::REG_RETRY_WAIT)    retry_wait    <= cfg_data;
    end
  end

  kfrt_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item(in_data),
    .q_valid, .q_pop, .q_item
  );

  kfrt_back u_back (
    .clk, .rst, .request_delay, .retry_wait,
    .q_valid, .q_pop, .q_item,
    .out_valid, .out_ready, .out_item(out_data)
  );
endmodule
`default_nettype wire

>>> rtl/core/kfrt_checker.sv
// Port-level checker for the key-frame request tracker, bound to the top level.
// Depends on kfrt_pkg.
`default_nettype none
module kfrt_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire kfrt_pkg::out_item_t out_data,
  input wire logic                in_valid,
  input wire logic                in_ready
);
  // Every result marks a sent request.
  a_req: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.request_valid) else $error("result without request");
  // Output holds while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  // Nothing comes out right after reset.
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result after reset");
  // The input handshake signals and out_valid are always known once out of reset.
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({in_valid, in_ready, out_valid}))
    else $error("unknown handshake signal");
endmodule

bind key_frame_request_tracker kfrt_checker u_checker (
  .clk, .rst, .out_valid, .out_ready, .out_data, .in_valid, .in_ready
);
`default_nettype wire

>>> bench/tb_key_frame_request_tracker.sv
// Testbench for the key-frame request tracker: random stimulus, a scoreboard and a predictor.
// Depends on kfrt_pkg and on the key_frame_request_tracker top level.
module tb_key_frame_request_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard with its own copy of the slot table and the registers.
  class request_scoreboard;
    logic [15:0] delay_cfg;
    logic [15:0] wait_cfg;
    logic [31:0] ids[kfrt_pkg::Slots];
    bit          pend_v[kfrt_pkg::Slots];
    bit          pend_r[kfrt_pkg::Slots];
    logic [15:0] pend_t[kfrt_pkg::Slots];
    bit          dly_v[kfrt_pkg::Slots];
    bit          dly_r[kfrt_pkg::Slots];
    logic [15:0] dly_t[kfrt_pkg::Slots];
    kfrt_pkg::out_item_t batch[$];
    kfrt_pkg::out_item_t expected_requests[$];
    int          mismatches;

    function new();
      delay_cfg = 16'd0;
      wait_cfg = kfrt_pkg::RetryWaitReset;
      mismatches = 0;
      for (int i = 0; i < kfrt_pkg::Slots; i++) begin
        ids[i] = '0;
        pend_v[i] = 0;
        pend_r[i] = 0;
        pend_t[i] = '0;
        dly_v[i] = 0;
        dly_r[i] = 0;
        dly_t[i] = '0;
      end
    endfunction

    function void write_reg(logic idx, logic [15:0] value);
      if (idx == kfrt_pkg::REG_REQUEST_DELAY) delay_cfg = value;
      else wait_cfg = value;
    endfunction

    function void send_request(logic [31:0] id, bit full);
      kfrt_pkg::out_item_t r;
      r.request_valid = 1'b1;
      r.request_stream = id;
      r.table_full = full;
      r.last = 1'b0;
      if (batch.size() < kfrt_pkg::MaxResults) batch.push_back(r);
    endfunction

    function int find_slot(logic [31:0] id);
      for (int i = 0; i < kfrt_pkg::Slots; i++)
        if ((pend_v[i] || dly_v[i]) && ids[i] == id) return i;
      return -1;
    endfunction

    function int take_slot(logic [31:0] id);
      for (int i = 0; i < kfrt_pkg::Slots; i++)
        if (!(pend_v[i] || dly_v[i])) begin
          ids[i] = id;
          return i;
        end
      return -1;
    endfunction

    function void arm_pending(int s);
      pend_v[s] = 1;
      pend_r[s] = 0;
      pend_t[s] = wait_cfg;
    endfunction

    function void arm_delayer(int s);
      dly_v[s] = 1;
      dly_r[s] = 0;
      dly_t[s] = delay_cfg;
    endfunction

    function void on_needed(logic [31:0] id);
      int s;
      s = find_slot(id);
      if (delay_cfg > 0) begin
        if (s >= 0 && dly_v[s]) begin
          dly_r[s] = 1;
          return;
        end
        if (s < 0) begin
          s = take_slot(id);
          if (s < 0) begin
            send_request(id, 1);
            return;
          end
        end
        arm_delayer(s);
      end
      if (s >= 0 && pend_v[s]) begin
        pend_r[s] = 1;
        return;
      end
      if (s < 0) begin
        s = take_slot(id);
        if (s < 0) begin
          send_request(id, 1);
          return;
        end
      end
      arm_pending(s);
      send_request(id, 0);
    endfunction

    function void on_forced(logic [31:0] id);
      int s;
      s = find_slot(id);
      if (s < 0) begin
        s = take_slot(id);
        if (s < 0) begin
          send_request(id, 1);
          return;
        end
      end
      if (delay_cfg > 0) arm_delayer(s);
      if (pend_v[s]) begin
        pend_r[s] = 1;
        pend_t[s] = wait_cfg;
      end else begin
        arm_pending(s);
      end
      send_request(id, 0);
    endfunction

    function void on_tick();
      bit          req;
      logic [31:0] id;
      // Pending timers first, then delayer timers, each in slot order.
      for (int i = 0; i < kfrt_pkg::Slots; i++) begin
        if (!pend_v[i]) continue;
        if (pend_t[i] > 1) begin
          pend_t[i]--;
        end else if (pend_r[i]) begin
          pend_r[i] = 0;
          pend_t[i] = wait_cfg;
          send_request(ids[i], 0);
        end else begin
          pend_v[i] = 0;
          pend_t[i] = '0;
        end
      end
      for (int i = 0; i < kfrt_pkg::Slots; i++) begin
        if (!dly_v[i]) continue;
        if (dly_t[i] > 1) begin
          dly_t[i]--;
        end else begin
          req = dly_r[i];
          id = ids[i];
          dly_v[i] = 0;
          dly_r[i] = 0;
          dly_t[i] = '0;
          if (req) on_needed(id);
        end
      end
    endfunction

    // Notes one accepted input transfer and queues the requests it causes.
    function void note_input(kfrt_pkg::in_item_t it);
      int s;
      batch.delete();
      case (kfrt_pkg::kind_t'(it.kind))
        kfrt_pkg::KIND_NEEDED: on_needed(it.stream_id);
        kfrt_pkg::KIND_FORCED: on_forced(it.stream_id);
        kfrt_pkg::KIND_RECEIVED: begin
          s = find_slot(it.stream_id);
          if (s >= 0 && pend_v[s]) begin
            pend_v[s] = 0;
            pend_r[s] = 0;
            pend_t[s] = '0;
          end
        end
        default: on_tick();
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) expected_requests.push_back(batch[i]);
    endfunction

    // Checks one output transfer against the oldest expected request.
    function void check_result(kfrt_pkg::out_item_t got);
      kfrt_pkg::out_item_t exp_r;
      if (expected_requests.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected request: stream %h full %b last %b",
                   got.request_stream, got.table_full, got.last);
        return;
      end
      exp_r = expected_requests.pop_front();
      if (got.request_valid !== exp_r.request_valid ||
          got.request_stream !== exp_r.request_stream ||
          got.table_full !== exp_r.table_full || got.last !== exp_r.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected v%b %h full %b last %b, got v%b %h full %b last %b",
                   exp_r.request_valid, exp_r.request_stream, exp_r.table_full, exp_r.last,
                   got.request_valid, got.request_stream, got.table_full, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  kfrt_pkg::in_item_t  in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  kfrt_pkg::out_item_t out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = kfrt_pkg::REG_REQUEST_DELAY;
  logic [15:0] cfg_data = '0;

  request_scoreboard sb = new();
  bit          long_hold = 0;
  logic [31:0] id_pool[24];

  key_frame_request_tracker u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Output side: mostly ready, short and occasional long stalls, one long hold.
  initial begin
    int r;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 0;
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(20, 60)) @(posedge clk);
          out_ready <= 1'b1;
        end else begin
          out_ready <= (r < 75);
        end
      end
    end
  end

  // Output monitor.
  always @(posedge clk)
    if (!rst && out_valid && out_ready) sb.check_result(out_data);

  // Random gap length: mostly short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Offers one item and waits for its transfer.
  task automatic send_item(kfrt_pkg::in_item_t it, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic send_event(kfrt_pkg::kind_t k, logic [31:0] id);
    kfrt_pkg::in_item_t it;
    it.kind = k;
    it.stream_id = id;
    send_item(it, pick_gap());
  endtask

  // Waits until every expected request has arrived, then until the queued
  // items without results have finished.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_requests.size() != 0) @(posedge clk);
    repeat (3 * (2 * kfrt_pkg::Slots + 2) + 20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic random_phase(int n, bit forced_burst);
    int r;
    logic [31:0] id;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      id = ($urandom_range(0, 9) == 0) ? $urandom() : id_pool[$urandom_range(0, 23)];
      if (forced_burst) send_event(kfrt_pkg::KIND_FORCED, id);
      else if (r < 4) send_event(kfrt_pkg::KIND_TICK, $urandom());
      else if (r < 7) send_event(kfrt_pkg::KIND_NEEDED, id);
      else if (r < 8) send_event(kfrt_pkg::KIND_FORCED, id);
      else send_event(kfrt_pkg::KIND_RECEIVED, id);
    end
  endtask

  initial begin
    for (int i = 0; i < 24; i++) id_pool[i] = $urandom();
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under reset settings: suppression, retry mark, received, full table.
    send_event(kfrt_pkg::KIND_NEEDED, 32'h0000_0000);
    send_event(kfrt_pkg::KIND_NEEDED, 32'hFFFF_FFFF);
    send_event(kfrt_pkg::KIND_NEEDED, 32'h0000_0000);
    send_event(kfrt_pkg::KIND_FORCED, 32'hFFFF_FFFF);
    send_event(kfrt_pkg::KIND_RECEIVED, 32'h0000_0000);
    send_event(kfrt_pkg::KIND_RECEIVED, 32'h1234_5678);
    send_event(kfrt_pkg::KIND_TICK, 32'hFFFF_FFFF);
    for (int i = 1; i <= 16; i++) send_event(kfrt_pkg::KIND_NEEDED, 32'hA5A5_0000 + i);
    send_event(kfrt_pkg::KIND_FORCED, 32'h5A5A_5A5A);
    drain();

    // Fast timers without delayers: everything expires, retries fire.
    write_reg(kfrt_pkg::REG_RETRY_WAIT, 16'd1);
    random_phase(25, 0);
    // Sender waits here until every request has come back.
    in_valid <= 1'b0;
    while (sb.expected_requests.size() != 0) @(posedge clk);
    random_phase(5, 0);
    drain();

    // Short delayers; a long receiver hold while forced requests keep coming.
    write_reg(kfrt_pkg::REG_REQUEST_DELAY, 16'd2);
    write_reg(kfrt_pkg::REG_RETRY_WAIT, 16'd3);
    long_hold = 1;
    random_phase(25, 1);
    random_phase(20, 0);
    drain();

    write_reg(kfrt_pkg::REG_REQUEST_DELAY, 16'd1);
    write_reg(kfrt_pkg::REG_RETRY_WAIT, 16'd1);
    random_phase(30, 0);
    drain();

    // Extreme settings: nothing expires, so the table fills up.
    write_reg(kfrt_pkg::REG_REQUEST_DELAY, 16'hFFFF);
    write_reg(kfrt_pkg::REG_RETRY_WAIT, 16'hFFFF);
    random_phase(25, 0);
    drain();

    write_reg(kfrt_pkg::REG_REQUEST_DELAY, 16'd0);
    write_reg(kfrt_pkg::REG_RETRY_WAIT, 16'd2);
    random_phase(25, 0);
    drain();

    if (sb.mismatches == 0 && sb.expected_requests.size() == 0)
      $display("tb_key_frame_request_tracker passed");
    else
      $display("tb_key_frame_request_tracker failed");
    $finish;
  end

  // Run limit.
  initial begin
    #20_000_000;
    $display("tb_key_frame_request_tracker failed");
    $finish;
  end
endmodule
